// ===== hdl/rabfz_pkg.sv =====
package rabfz_pkg;

  localparam int unsigned POS_W     = 11;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned OFS_W     = 6;
  localparam int unsigned WIDX_W    = POS_W - OFS_W;
  localparam int unsigned PC_W      = OFS_W + 1;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_COUNT  = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  typedef struct packed {
    logic [WORD_BITS-1:0] wdata;
    logic [PC_W-1:0]      ones;
    logic                 zfound;
    logic [OFS_W-1:0]     zidx;
  } word_res_t;

endpackage

// ===== hdl/rabfz_word.sv =====
module rabfz_word
  import rabfz_pkg::*;
(
  input  logic [1:0]           op_i,
  input  logic [WORD_BITS-1:0] rdata_i,
  input  logic                 first_i,
  input  logic                 last_i,
  input  logic [OFS_W-1:0]     st_ofs_i,
  input  logic [OFS_W-1:0]     ed_ofs_i,
  output word_res_t            res_o
);

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] ones_in;
  logic [WORD_BITS-1:0] zeros_in;

  assign lo_mask  = first_i ? ({WORD_BITS{1'b1}} << st_ofs_i) : {WORD_BITS{1'b1}};
  assign hi_mask  = last_i ? ({WORD_BITS{1'b1}} >> (OFS_W'(WORD_BITS - 1) - ed_ofs_i))
                           : {WORD_BITS{1'b1}};
  assign mask     = lo_mask & hi_mask;
  assign ones_in  = rdata_i & mask;
  assign zeros_in = ~rdata_i & mask;

  always_comb begin
    res_o = '0;
    case (op_i)
      OP_SET:   res_o.wdata = rdata_i | mask;
      OP_CLEAR: res_o.wdata = rdata_i & ~mask;
      default:  res_o.wdata = rdata_i;
    endcase
    for (int i = 0; i < WORD_BITS; i++) begin
      res_o.ones = res_o.ones + PC_W'(ones_in[i]);
    end
    // lowest zero wins
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (zeros_in[i]) begin
        res_o.zidx = OFS_W'(i);
      end
    end
    res_o.zfound = |zeros_in;
  end

endmodule

// ===== hdl/range_assign_bitmap_first_zero.sv =====
// Bitmap over positions 1..S (S = active_size clamped to 1..MAX_POSITIONS) kept as
// 64-bit words in one synchronous RAM. Ops on an inclusive range, clipped to 1..S
// (start 0 acts as 1): set to ones, clear, count ones, find lowest zero. Each op
// sweeps the RAM words its range covers, one read-modify-write per cycle with the
// read of the next word overlapped, and a search ends at the first word holding a
// zero; an empty range goes straight to the result. Writing active_size clears the
// bitmap at once through per-word valid flops (no clearing pass); write it only
// while idle. One result word per input word; the output register lets the result wait.
module range_assign_bitmap_first_zero
  import rabfz_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_wdata_i,     // active_size
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,    // op[1:0], range_start[12:2], range_end[23:13]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata     // ones_count[10:0], zero_position[21:11],
                                            // found[22], zero[23]
);

  // highest position an 11-bit field can reach
  localparam int unsigned MAX_CLIP_I = (MAX_POSITIONS > 2047) ? 2047 : MAX_POSITIONS;
  localparam logic [POS_W-1:0] MAX_CLIP = POS_W'(MAX_CLIP_I);
  localparam int unsigned DEPTH = (MAX_CLIP_I >> OFS_W) + 1;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [POS_W-1:0]  size_q;
  logic [1:0]        op_q;
  logic [POS_W-1:0]  st_q, ed_q;
  logic [WIDX_W-1:0] wrd_q, wrd_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              fnd_q, fnd_d;
  logic              out_vld_q;
  logic [23:0]       out_data_q;
  logic [DEPTH-1:0]  vld_q;

  // RAM
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;
  logic                 mem_re, mem_we;
  logic [WIDX_W-1:0]    raddr;

  // input decode and clipping
  logic [1:0]       in_op;
  logic [POS_W-1:0] in_st, in_ed, eff_size, st_c, ed_c;
  logic             accept, empty;

  assign in_op = s_axis_tdata[1:0];
  assign in_st = s_axis_tdata[12:2];
  assign in_ed = s_axis_tdata[23:13];

  assign eff_size = (size_q == '0) ? POS_W'(1) : ((size_q > MAX_CLIP) ? MAX_CLIP : size_q);
  assign st_c     = (in_st == '0) ? POS_W'(1) : in_st;
  assign ed_c     = (in_ed > eff_size) ? eff_size : in_ed;
  assign empty    = st_c > ed_c;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // word unit
  word_res_t wres;
  logic      is_last;

  assign is_last = (wrd_q == ed_q[POS_W-1:OFS_W]);

  rabfz_word u_word (
    .op_i     (op_q),
    .rdata_i  (rvld_q ? rdata_q : '0),
    .first_i  (wrd_q == st_q[POS_W-1:OFS_W]),
    .last_i   (is_last),
    .st_ofs_i (st_q[OFS_W-1:0]),
    .ed_ofs_i (ed_q[OFS_W-1:0]),
    .res_o    (wres)
  );

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    wrd_d   = wrd_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    fnd_d   = fnd_q;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    raddr   = wrd_q + WIDX_W'(1);
    case (state_q)
      ST_IDLE: begin
        raddr = st_c[POS_W-1:OFS_W];
        if (accept) begin
          cnt_d = '0;
          pos_d = '0;
          fnd_d = 1'b0;
          wrd_d = st_c[POS_W-1:OFS_W];
          if (empty) begin
            state_d = ST_FIN;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        mem_we = (op_q == OP_SET) || (op_q == OP_CLEAR);
        cnt_d  = cnt_q + POS_W'(wres.ones);
        if ((op_q == OP_SEARCH) && wres.zfound) begin
          pos_d   = {wrd_q, wres.zidx};
          fnd_d   = 1'b1;
          state_d = ST_FIN;
        end else if (is_last) begin
          state_d = ST_FIN;
        end else begin
          mem_re = 1'b1;
          wrd_d  = wrd_q + WIDX_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM: next-word read never hits the word being written
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wrd_q[AW-1:0]] <= wres.wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else if (mem_re) begin
      rvld_q <= vld_q[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      size_q    <= POS_W'(1024);
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
        vld_q  <= '0;
      end else if (mem_we) begin
        vld_q[wrd_q[AW-1:0]] <= 1'b1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_op;
      st_q <= st_c;
      ed_q <= ed_c;
    end
    wrd_q <= wrd_d;
    cnt_q <= cnt_d;
    pos_q <= pos_d;
    fnd_q <= fnd_d;
    if (state_q == ST_FIN && out_free) begin
      out_data_q <= {1'b0, fnd_q,
                     (op_q == OP_SEARCH) ? pos_q : POS_W'(0),
                     (op_q == OP_COUNT) ? cnt_q : POS_W'(0)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE))
    else $error("ready outside idle");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (vld_q == '0))
    else $error("valid bits not cleared by size write");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_RUN))
    else $error("RAM write outside sweep");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> out_vld_q)
    else $error("result not loaded");

endmodule
